[sv/rbsm_pkg.sv]
`timescale 1ns / 1ps

package rbsm_pkg;

	// default sizes of the descriptor table and the byte ring
	localparam int DEF_ENTRIES     = 16;
	localparam int DEF_STORE_BYTES = 1024;
	localparam int DEF_ENTRY_W     = 4;
	localparam int DEF_ADDR_W      = 10;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_SPLIT = 2'd1,
		KIND_MERGE = 2'd2,
		KIND_WRITE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_BLOCKED    = 3'd1,
		STS_SHORT      = 3'd2,
		STS_NO_SPARE   = 3'd3,
		STS_NO_FOLLOW  = 3'd4,
		STS_WHOLE_RING = 3'd5,
		STS_OUTSIDE    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_EVAL,
		S_SPLIT_SCAN,
		S_SPLIT_OLD,
		S_MERGE_SCAN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    rd_entry;
		logic    take_e;
		logic    do_load;
		logic    do_byte;
		logic    scan_step;
		logic    split_new;
		logic    split_old;
		logic    merge_commit;
		logic    set_status;
		status_t status_code;
		logic    publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  blocked;
		logic  too_short;
		logic  whole_ring;
		logic  off_inside;
		logic  scan_end;
		logic  spare_hit;
		logic  follow_hit;
		logic  merge_end;
	} sts_t;

endpackage

[sv/rbsm_req_if.sv]
`timescale 1ns / 1ps

interface rbsm_req_if #(
	parameter int ENTRY_W = rbsm_pkg::DEF_ENTRY_W,
	parameter int ADDR_W  = rbsm_pkg::DEF_ADDR_W
);
	logic                valid;
	logic                ready;
	rbsm_pkg::kind_t     kind;
	logic [ENTRY_W-1:0]  entry;
	logic [ADDR_W-1:0]   start_req;
	logic [ADDR_W:0]     length;
	logic                busy_flag;
	logic                present_flag;
	logic [ADDR_W-1:0]   offset;
	logic [7:0]          data_byte;

	modport source (
		output valid, kind, entry, start_req, length, busy_flag, present_flag, offset,
		       data_byte,
		input  ready
	);

	modport sink (
		input  valid, kind, entry, start_req, length, busy_flag, present_flag, offset,
		       data_byte,
		output ready
	);
endinterface

[sv/rbsm_rsp_if.sv]
`timescale 1ns / 1ps

interface rbsm_rsp_if #(
	parameter int ENTRY_W = rbsm_pkg::DEF_ENTRY_W,
	parameter int ADDR_W  = rbsm_pkg::DEF_ADDR_W
);
	logic                valid;
	logic                ready;
	rbsm_pkg::status_t   status;
	logic [ENTRY_W-1:0]  new_entry;
	logic [ADDR_W-1:0]   entry_start;
	logic [ADDR_W:0]     entry_length;
	logic [ADDR_W-1:0]   byte_address;

	modport source (
		output valid, status, new_entry, entry_start, entry_length, byte_address,
		input  ready
	);

	modport sink (
		input  valid, status, new_entry, entry_start, entry_length, byte_address,
		output ready
	);
endinterface

[sv/rbsm_ram.sv]
`timescale 1ns / 1ps

module rbsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

[sv/rbsm_ctrl.sv]
`timescale 1ns / 1ps

module rbsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  rbsm_pkg::sts_t sts,
	output rbsm_pkg::cmd_t cmd
);
	import rbsm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.rd_entry = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				cmd.take_e = 1'b1;
				state_d    = S_DONE;
				if (!sts.in_range) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STS_BLOCKED;
				end else begin
					case (sts.kind)
						KIND_LOAD: begin
							cmd.do_load = 1'b1;
						end
						KIND_WRITE: begin
							if (sts.off_inside) begin
								cmd.do_byte = 1'b1;
							end else begin
								cmd.set_status  = 1'b1;
								cmd.status_code = STS_OUTSIDE;
							end
						end
						KIND_SPLIT: begin
							if (sts.blocked) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = STS_BLOCKED;
							end else if (sts.too_short) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = STS_SHORT;
							end else begin
								state_d = S_SPLIT_SCAN;
							end
						end
						KIND_MERGE: begin
							if (sts.blocked) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = STS_BLOCKED;
							end else if (sts.whole_ring) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = STS_WHOLE_RING;
							end else begin
								state_d = S_MERGE_SCAN;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SPLIT_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STS_NO_SPARE;
					state_d         = S_DONE;
				end else if (sts.spare_hit) begin
					cmd.split_new = 1'b1;
					state_d       = S_SPLIT_OLD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SPLIT_OLD: begin
				cmd.split_old = 1'b1;
				state_d       = S_DONE;
			end
			S_MERGE_SCAN: begin
				if (sts.follow_hit) begin
					cmd.merge_commit = 1'b1;
					state_d          = S_DONE;
				end else if (sts.merge_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STS_NO_FOLLOW;
					state_d         = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

[sv/rbsm_datapath.sv]
`timescale 1ns / 1ps

module rbsm_datapath #(
	parameter int ENTRIES     = rbsm_pkg::DEF_ENTRIES,
	parameter int STORE_BYTES = rbsm_pkg::DEF_STORE_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rbsm_pkg::cmd_t                   cmd,
	output rbsm_pkg::sts_t                   sts,
	input  rbsm_pkg::kind_t                  kind,
	input  logic [$clog2(ENTRIES)-1:0]       entry,
	input  logic [$clog2(STORE_BYTES)-1:0]   start_req,
	input  logic [$clog2(STORE_BYTES):0]     length,
	input  logic                             busy_flag,
	input  logic                             present_flag,
	input  logic [$clog2(STORE_BYTES)-1:0]   offset,
	input  logic [7:0]                       data_byte,
	output rbsm_pkg::status_t                status,
	output logic [$clog2(ENTRIES)-1:0]       new_entry,
	output logic [$clog2(STORE_BYTES)-1:0]   entry_start,
	output logic [$clog2(STORE_BYTES):0]     entry_length,
	output logic [$clog2(STORE_BYTES)-1:0]   byte_address
);
	import rbsm_pkg::*;

	localparam int EW         = $clog2(ENTRIES);
	localparam int CW         = $clog2(ENTRIES + 1);
	localparam int AW         = $clog2(STORE_BYTES);
	localparam int LW         = AW + 1;
	localparam int SW         = AW + 2;
	localparam int DW         = AW + LW;
	localparam bit IS_POW2    = (STORE_BYTES & (STORE_BYTES - 1)) == 0;
	localparam int WRAP_STEPS = 4;

	// sums stay below five ring sizes, so four conditional subtracts wrap them
	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] v);
		logic [SW-1:0] r;
		r = v;
		if (!IS_POW2) begin
			for (int k = 0; k < WRAP_STEPS; k++) begin
				if (r >= SW'(STORE_BYTES)) begin
					r = r - SW'(STORE_BYTES);
				end
			end
		end
		return r[AW-1:0];
	endfunction

	// captured request
	kind_t         kind_q;
	logic [EW-1:0] entry_q;
	logic [AW-1:0] start_req_q;
	logic [LW-1:0] len_req_q;
	logic          busy_in_q;
	logic          pres_in_q;
	logic [AW-1:0] off_q;
	logic [7:0]    data_q;

	// per-descriptor flags
	logic [ENTRIES-1:0] busy_q;
	logic [ENTRIES-1:0] present_q;
	logic [ENTRIES-1:0] written_q;

	// working values
	logic [AW-1:0] e_start_q;
	logic [LW-1:0] e_len_q;
	logic [AW-1:0] follow_q;
	status_t       status_q;
	logic [EW-1:0] new_entry_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] scan_q;
	logic          chk_vld_s1;
	logic [EW-1:0] chk_idx_s1;

	// result register
	status_t       rsp_status_q;
	logic [EW-1:0] rsp_new_q;
	logic [AW-1:0] rsp_start_q;
	logic [LW-1:0] rsp_len_q;
	logic [AW-1:0] rsp_addr_q;

	logic          desc_wr_en;
	logic [EW-1:0] desc_wr_addr;
	logic [DW-1:0] desc_wr_data;
	logic          desc_rd_en;
	logic [EW-1:0] desc_rd_addr;
	logic [DW-1:0] desc_rd_data;
	logic [AW-1:0] ram_start;
	logic [LW-1:0] ram_len;

	logic          in_range;
	logic [EW-1:0] e_idx;
	logic          cur_ok;
	logic [AW-1:0] cur_start;
	logic [LW-1:0] cur_len;
	logic [AW-1:0] cur_end;
	logic [AW-1:0] byte_addr_w;
	logic [EW-1:0] scan_idx;
	logic          scan_live;
	logic [LW:0]   merge_sum;
	logic [LW-1:0] merge_len;
	logic [AW-1:0] split_start;
	logic [LW-1:0] split_rem;
	logic [AW-1:0] load_start;

	assign ram_start = desc_rd_data[DW-1 -: AW];
	assign ram_len   = desc_rd_data[LW-1:0];

	assign in_range  = (EW + 1)'(entry_q) < (EW + 1)'(ENTRIES);
	assign e_idx     = in_range ? entry_q : '0;
	assign cur_ok    = in_range && written_q[e_idx];
	assign cur_start = cur_ok ? ram_start : '0;
	assign cur_len   = cur_ok ? ram_len : '0;
	assign cur_end   = wrap(SW'(cur_start) + SW'(cur_len));
	assign byte_addr_w = wrap(SW'(cur_start) + SW'(off_q));
	assign load_start  = wrap(SW'(start_req_q));

	assign scan_idx  = scan_q[EW-1:0];
	assign scan_live = scan_q != CW'(ENTRIES);

	assign merge_sum = (LW + 1)'(e_len_q) + (LW + 1)'(ram_len);
	assign merge_len = (merge_sum > (LW + 1)'(STORE_BYTES)) ? LW'(STORE_BYTES)
	                                                       : merge_sum[LW-1:0];
	assign split_start = wrap(SW'(e_start_q) + SW'(len_req_q));
	assign split_rem   = e_len_q - len_req_q;

	assign sts.kind       = kind_q;
	assign sts.in_range   = in_range;
	assign sts.blocked    = !(in_range && present_q[e_idx]) || (in_range && busy_q[e_idx]);
	assign sts.too_short  = cur_len < len_req_q;
	assign sts.whole_ring = cur_end == cur_start;
	assign sts.off_inside = LW'(off_q) < cur_len;
	assign sts.scan_end   = !scan_live;
	assign sts.spare_hit  = scan_live && !present_q[scan_idx];
	assign sts.follow_hit = chk_vld_s1 && (chk_idx_s1 != entry_q) && !busy_q[chk_idx_s1]
	                        && present_q[chk_idx_s1] && (ram_start == follow_q);
	assign sts.merge_end  = !scan_live && !chk_vld_s1;

	// descriptor table port selection
	always_comb begin
		desc_wr_en   = cmd.do_load || cmd.split_new || cmd.split_old || cmd.merge_commit;
		desc_wr_addr = e_idx;
		desc_wr_data = {e_start_q, len_req_q};
		if (cmd.do_load) begin
			desc_wr_data = {load_start, len_req_q};
		end else if (cmd.split_new) begin
			desc_wr_addr = scan_idx;
			desc_wr_data = {split_start, split_rem};
		end else if (cmd.merge_commit) begin
			desc_wr_data = {e_start_q, merge_len};
		end
	end

	assign desc_rd_en   = cmd.rd_entry || (cmd.scan_step && scan_live);
	assign desc_rd_addr = cmd.scan_step ? scan_idx : e_idx;

	rbsm_ram #(
		.WIDTH (DW),
		.DEPTH (ENTRIES)
	) u_desc_ram (
		.clk     (clk),
		.wr_en   (desc_wr_en),
		.wr_addr (desc_wr_addr),
		.wr_data (desc_wr_data),
		.rd_en   (desc_rd_en),
		.rd_addr (desc_rd_addr),
		.rd_data (desc_rd_data)
	);

	rbsm_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_byte_ram (
		.clk     (clk),
		.wr_en   (cmd.do_byte),
		.wr_addr (byte_addr_w),
		.wr_data (data_q),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	// flags and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			present_q  <= '0;
			written_q  <= '0;
			scan_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= cmd.scan_step && scan_live;
			if (cmd.take_e) begin
				scan_q <= '0;
			end else if (cmd.scan_step && scan_live) begin
				scan_q <= scan_q + CW'(1);
			end
			if (cmd.do_load) begin
				written_q[e_idx] <= 1'b1;
				busy_q[e_idx]    <= busy_in_q;
				present_q[e_idx] <= pres_in_q;
			end
			if (cmd.split_new) begin
				written_q[scan_idx] <= 1'b1;
				busy_q[scan_idx]    <= 1'b0;
				present_q[scan_idx] <= 1'b1;
			end
			if (cmd.merge_commit) begin
				busy_q[chk_idx_s1]    <= 1'b0;
				present_q[chk_idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= scan_idx;
		if (cmd.capture) begin
			kind_q      <= kind;
			entry_q     <= entry;
			start_req_q <= start_req;
			len_req_q   <= length;
			busy_in_q   <= busy_flag;
			pres_in_q   <= present_flag;
			off_q       <= offset;
			data_q      <= data_byte;
			status_q    <= STS_OK;
			new_entry_q <= '0;
			addr_q      <= '0;
		end
		// a load replaces the descriptor it reads, so its new values win
		if (cmd.do_load) begin
			e_start_q <= load_start;
			e_len_q   <= len_req_q;
		end else if (cmd.take_e) begin
			e_start_q <= cur_start;
			e_len_q   <= cur_len;
			follow_q  <= cur_end;
		end else if (cmd.split_old) begin
			e_len_q <= len_req_q;
		end else if (cmd.merge_commit) begin
			e_len_q <= merge_len;
		end
		if (cmd.do_byte) begin
			addr_q <= byte_addr_w;
		end
		if (cmd.split_new) begin
			new_entry_q <= scan_idx;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.publish) begin
			rsp_status_q <= status_q;
			rsp_new_q    <= new_entry_q;
			rsp_start_q  <= e_start_q;
			rsp_len_q    <= e_len_q;
			rsp_addr_q   <= addr_q;
		end
	end

	assign status       = rsp_status_q;
	assign new_entry    = rsp_new_q;
	assign entry_start  = rsp_start_q;
	assign entry_length = rsp_len_q;
	assign byte_address = rsp_addr_q;
endmodule

[sv/ring_block_split_merge_table.sv]
`timescale 1ns / 1ps

// channel | dir | handshake    | payload
// --------+-----+--------------+---------------------------------------------------------
// req     | in  | valid, ready | kind, entry, start_req, length, busy_flag, present_flag,
//         |     |              | offset, data_byte
// rsp     | out | valid, ready | status, new_entry, entry_start, entry_length, byte_address
//
// one request at a time; load, write byte and an entry out of range pass through the
// look, evaluate and done states to the response, split and merge add a scan of the
// descriptor table walking one descriptor per cycle through its single read port
// arst_n clears the state machine, the response valid and all descriptor flags, so
// every descriptor reads as unused with start and length zero; no clearing pass
// the response sits in an output register: a new request is accepted while it waits,
// and the next response is held back until the previous one has been taken

module ring_block_split_merge_table #(
	parameter int ENTRIES     = rbsm_pkg::DEF_ENTRIES,
	parameter int STORE_BYTES = rbsm_pkg::DEF_STORE_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	rbsm_req_if.sink   req,
	rbsm_rsp_if.source rsp
);
	import rbsm_pkg::*;

	// command and status between the sequencer and the table datapath
	cmd_t cmd;
	sts_t sts;

	logic ctl_req_ready;
	logic ctl_rsp_valid;

	// sequencer: request intake, operation decode, table scans, response handoff
	rbsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctl_req_ready),
		.rsp_valid (ctl_rsp_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: descriptor ram with flags, byte ring ram, wrap arithmetic, result register
	rbsm_datapath #(
		.ENTRIES     (ENTRIES),
		.STORE_BYTES (STORE_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (req.kind),
		.entry        (req.entry),
		.start_req    (req.start_req),
		.length       (req.length),
		.busy_flag    (req.busy_flag),
		.present_flag (req.present_flag),
		.offset       (req.offset),
		.data_byte    (req.data_byte),
		.status       (rsp.status),
		.new_entry    (rsp.new_entry),
		.entry_start  (rsp.entry_start),
		.entry_length (rsp.entry_length),
		.byte_address (rsp.byte_address)
	);

	assign req.ready = ctl_req_ready;
	assign rsp.valid = ctl_rsp_valid;
endmodule
